>>> src/wli_pkg.sv
// Shared types and constants for the waypoint linear interpolator.
`default_nettype none
package wli_pkg;
    localparam int NUM_COMP = 6;
    localparam int VAL_W    = 32;
    localparam int TIME_W   = 32;

    typedef enum logic [0:0] {
        OP_APPEND = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef val_t [NUM_COMP-1:0] vec_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SREQ   = 10'b0000000010,
        ST_SCMP   = 10'b0000000100,
        ST_RD0    = 10'b0000001000,
        ST_RD1    = 10'b0000010000,
        ST_CAP0   = 10'b0000100000,
        ST_DIV    = 10'b0001000000,
        ST_MUL    = 10'b0010000000,
        ST_ENDP   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;
endpackage
`default_nettype wire

>>> src/wli_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module wli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] addr,
    input  wire [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/wli_divider.sv
// Restoring divider producing the interpolation fraction one bit per cycle.
`default_nettype none
module wli_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       go,
    input  wire [31:0]                num,
    input  wire [31:0]                den,
    output logic                      done,
    output logic [FRACTION_BITS-1:0]  quo
);
    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic [32:0]              rem_reg, rem_next;
    logic [31:0]              den_reg;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]            cnt_reg;
    logic                     busy_reg;
    logic [33:0]              trial;

    // num < den on interpolating queries, so remainder fits in 33 bits after the shift
    always_comb
    begin
        trial    = {rem_reg, 1'b0} - {2'b00, den_reg};
        rem_next = {rem_reg[31:0], 1'b0};
        quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b0};
        if (!trial[33])
        begin
            rem_next = trial[32:0];
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(FRACTION_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;
endmodule
`default_nettype wire

>>> src/waypoint_linear_interpolator.sv
// Top level of the waypoint linear interpolator.
// An append word returns to idle after its write state, ST_SREQ, and a query
// on an empty table goes from ST_SREQ straight to ST_DONE. A query whose time
// falls before the first or at or after the last stored time also passes
// through ST_ENDP. A query makes at most ceil(log2(entries + 1)) binary-search
// probes, and each probe takes a request state and a compare state (ST_SREQ,
// ST_SCMP) because the time memory has a registered read. The fraction comes
// from a one-bit-per-cycle divider, and the six components are scaled one per
// cycle through a single multiplier. busy stays high from accept through the
// result strobe. Results appear on the out_* ports for one cycle with valid
// high and cannot be held off.
`default_nettype none
module waypoint_linear_interpolator
    import wli_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 256,
    parameter int FRACTION_BITS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               operation,
    input  wire [31:0]        sample_time,
    input  wire signed [31:0] pos_radial,
    input  wire signed [31:0] pos_transverse,
    input  wire signed [31:0] pos_normal,
    input  wire signed [31:0] vel_radial,
    input  wire signed [31:0] vel_transverse,
    input  wire signed [31:0] vel_normal,
    output logic              valid,
    output logic signed [31:0] out_pos_radial,
    output logic signed [31:0] out_pos_transverse,
    output logic signed [31:0] out_pos_normal,
    output logic signed [31:0] out_vel_radial,
    output logic signed [31:0] out_vel_transverse,
    output logic signed [31:0] out_vel_normal,
    output logic              table_empty
);
    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int PW = 34 + FRACTION_BITS;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [AW-1:0] addr;
    logic          we_t, we_v;
    logic [31:0]   time_rd;
    vec_t          val_wd, val_rd;
    logic [31:0]   t_reg, last_t_reg, t0_reg;
    vec_t          v0_reg, v1_reg, res_reg;
    logic [2:0]    comp_reg;
    logic          is_append_reg, empty_reg, valid_reg;
    logic          div_go, div_done;
    logic [FRACTION_BITS-1:0] frac;
    logic signed [PW-1:0]     prod_reg;
    logic [2:0]    mul_idx_reg;
    logic          mul_busy_reg;
    logic [CW-1:0] mid;
    logic [CW-1:0] raddr_sel;
    logic          accept;

    // Take a word only when the block shows idle.
    assign accept = start && !busy;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Time store and one wide store holding the six values; both share one address.
    wli_ram #(.WIDTH(TIME_W), .DEPTH(MAX_WAYPOINTS)) u_time (
        .clk(clk), .we(we_t), .addr(addr), .wdata(t_reg), .rdata(time_rd));

    wli_ram #(.WIDTH(NUM_COMP * VAL_W), .DEPTH(MAX_WAYPOINTS)) u_vals (
        .clk(clk), .we(we_v), .addr(addr), .wdata(val_wd), .rdata(val_rd));

    assign addr = raddr_sel[AW-1:0];

    // Append writes happen in ST_SREQ reusing the capture of the word.
    always_comb
    begin
        we_t = 1'b0;
        raddr_sel = mid;
        case (state_reg)
            ST_SREQ:
            begin
                if (is_append_reg)
                begin
                    raddr_sel = count_reg;
                    we_t = (count_reg != CW'(MAX_WAYPOINTS)) &&
                           ((count_reg == '0) || (t_reg >= last_t_reg));
                end
            end
            ST_RD0:  raddr_sel = hi_reg - 1'b1;
            ST_RD1:  raddr_sel = hi_reg;
            ST_ENDP: raddr_sel = (hi_reg == '0) ? '0 : count_reg - 1'b1;
            default: raddr_sel = mid;
        endcase
    end
    assign we_v = we_t;

    logic [31:0] num_w, den_w;
    assign num_w = t_reg - t0_reg;
    assign den_w = time_rd - t0_reg;

    wli_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(num_w), .den(den_w),
        .done(div_done), .quo(frac));

    // ST_RD1 returns t1 in ST_CAP0; start the divider then (den nonzero unless end-point).
    assign div_go = (state_reg == ST_CAP0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SREQ;
            ST_SREQ:
            begin
                if (is_append_reg)       state_next = ST_IDLE;
                else if (empty_reg)      state_next = ST_DONE;
                else if (lo_reg < hi_reg) state_next = ST_SCMP;
                else if (hi_reg == count_reg || hi_reg == '0) state_next = ST_ENDP;
                else                     state_next = ST_RD0;
            end
            ST_SCMP:  state_next = ST_SREQ;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_CAP0;
            ST_CAP0:  state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   if (mul_busy_reg && mul_idx_reg == 3'(NUM_COMP)) state_next = ST_DONE;
            ST_ENDP:  state_next = ST_RD0;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            valid_reg    <= 1'b0;
            mul_busy_reg <= 1'b0;
            mul_idx_reg  <= '0;
            comp_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == ST_DONE);
            if (we_t)
            begin
                count_reg <= count_reg + 1'b1;
            end
            // Walk the six components: multiply into prod_reg, then accumulate from it into res_reg.
            if (state_reg == ST_DIV && div_done)
            begin
                mul_busy_reg <= 1'b1;
                mul_idx_reg  <= '0;
                comp_reg     <= '0;
            end
            else if (state_reg == ST_MUL)
            begin
                if (mul_idx_reg == 3'(NUM_COMP))
                begin
                    mul_busy_reg <= 1'b0;
                end
                else
                begin
                    mul_idx_reg <= mul_idx_reg + 1'b1;
                end
                comp_reg <= mul_idx_reg;
            end
        end
    end

    logic signed [32:0] diff;
    assign diff = 33'(v1_reg[mul_idx_reg]) - 33'(v0_reg[mul_idx_reg]);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_append_reg <= (operation == OP_APPEND);
                    empty_reg     <= (count_reg == '0);
                    t_reg         <= sample_time;
                    val_wd        <= {vel_normal, vel_transverse, vel_radial,
                                      pos_normal, pos_transverse, pos_radial};
                    lo_reg        <= '0;
                    hi_reg        <= count_reg;
                end
            end
            ST_SREQ:
            begin
                if (we_t)
                begin
                    last_t_reg <= t_reg;
                end
                if (empty_reg && !is_append_reg)
                begin
                    res_reg <= '0;
                end
            end
            ST_SCMP:
            begin
                // Advance the search window on the fetched probe.
                if (time_rd > t_reg) hi_reg <= mid;
                else                 lo_reg <= mid + 1'b1;
            end
            ST_ENDP:
            begin
                // Fetch the end entry through the same read path as t0.
                hi_reg <= ((hi_reg == '0) ? '0 : count_reg - 1'b1) + 1'b1;
                lo_reg <= CW'(1);
            end
            ST_RD1:
            begin
                t0_reg <= time_rd;
                v0_reg <= val_rd;
            end
            ST_CAP0:
            begin
                v1_reg <= val_rd;
            end
            ST_MUL:
            begin
                if (mul_idx_reg != 3'(NUM_COMP))
                begin
                    prod_reg <= PW'(diff) * $signed({1'b0, frac});
                end
                if (mul_idx_reg != '0)
                begin
                    res_reg[comp_reg] <= v0_reg[comp_reg] +
                        32'(prod_reg >>> FRACTION_BITS);
                end
            end
            default:
            begin
            end
        endcase
    end

    // End-point queries: lo_reg was forced to 1 in ST_ENDP; the divider
    // then works on the end entry and an entry past it, so override the result.
    logic endp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            endp_reg <= 1'b0;
        end
        else if (state_reg == ST_IDLE)
        begin
            endp_reg <= 1'b0;
        end
        else if (state_reg == ST_ENDP)
        begin
            endp_reg <= 1'b1;
        end
    end

    vec_t res_out;
    assign res_out = endp_reg ? v0_reg : res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            out_pos_radial     <= res_out[0];
            out_pos_transverse <= res_out[1];
            out_pos_normal     <= res_out[2];
            out_vel_radial     <= res_out[3];
            out_vel_transverse <= res_out[4];
            out_vel_normal     <= res_out[5];
            table_empty        <= empty_reg;
        end
    end

    assign valid = valid_reg;
    assign busy  = (state_reg != ST_IDLE) || valid_reg;
endmodule
`default_nettype wire

>>> src/wli_checker.sv
// Port-level checker for the waypoint linear interpolator.
`default_nettype none
module wli_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire valid,
    input wire table_empty,
    input wire signed [31:0] out_pos_radial,
    input wire signed [31:0] out_vel_normal
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("no busy after start");
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("valid while idle");
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid) else $error("valid longer than one cycle");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && table_empty |-> out_pos_radial == 0 && out_vel_normal == 0)
        else $error("empty result not zero");
endmodule

bind waypoint_linear_interpolator wli_checker u_wli_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .valid(valid),
    .table_empty(table_empty), .out_pos_radial(out_pos_radial),
    .out_vel_normal(out_vel_normal));
`default_nettype wire

>>> tb/waypoint_linear_interpolator_test.sv
// Testbench for the waypoint linear interpolator: directed and random appends and queries.
`default_nettype none
module waypoint_linear_interpolator_test;
    import wli_pkg::*;

    localparam int DEPTH      = 256;
    localparam int FRAC_BITS  = 16;
    localparam int CYCLE_CAP  = 1000000;
    localparam int QUIET_WAIT = 80;

    // One result word as the block presents it.
    typedef struct {
        vec_t vals;
        logic empty;
    } state_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic operation = 1'b0;
    logic [31:0] sample_time = '0;
    logic signed [31:0] pos_radial = '0, pos_transverse = '0, pos_normal = '0;
    logic signed [31:0] vel_radial = '0, vel_transverse = '0, vel_normal = '0;
    wire busy, valid, table_empty;
    wire signed [31:0] out_pos_radial, out_pos_transverse, out_pos_normal;
    wire signed [31:0] out_vel_radial, out_vel_transverse, out_vel_normal;

    waypoint_linear_interpolator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .sample_time(sample_time),
        .pos_radial(pos_radial), .pos_transverse(pos_transverse),
        .pos_normal(pos_normal), .vel_radial(vel_radial),
        .vel_transverse(vel_transverse), .vel_normal(vel_normal),
        .valid(valid), .out_pos_radial(out_pos_radial),
        .out_pos_transverse(out_pos_transverse), .out_pos_normal(out_pos_normal),
        .out_vel_radial(out_vel_radial), .out_vel_transverse(out_vel_transverse),
        .out_vel_normal(out_vel_normal), .table_empty(table_empty)
    );

    always #5 clk = ~clk;

    // Shadow copy of the waypoint table.
    int unsigned  waypoint_count;
    logic [31:0]  waypoint_time [DEPTH];
    vec_t         waypoint_vals [DEPTH];

    state_word_t  pending_states[$];
    int           mismatch_count;
    int           cycle_count;

    // Count cycles; end the run on a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycle_count, pending_states.size());
            $display("waypoint_linear_interpolator_test NOT OK");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Interpolate the shadow table at query time t.
    function automatic state_word_t interpolate_state(input logic [31:0] t);
        state_word_t w;
        int unsigned lo, hi, mid, i0;
        logic [63:0] num, den, f;
        logic signed [63:0] v0, v1, p;
        w.empty = 1'b0;
        w.vals = '0;
        if (waypoint_count == 0)
        begin
            w.empty = 1'b1;
            return w;
        end
        lo = 0;
        hi = waypoint_count;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (waypoint_time[mid] > t) hi = mid;
            else lo = mid + 1;
        end
        if (lo == 0)
        begin
            w.vals = waypoint_vals[0];
            return w;
        end
        if (lo == waypoint_count)
        begin
            w.vals = waypoint_vals[waypoint_count - 1];
            return w;
        end
        i0 = lo - 1;
        num = {32'b0, t - waypoint_time[i0]} << FRAC_BITS;
        den = {32'b0, waypoint_time[lo] - waypoint_time[i0]};
        f = (den != 0) ? num / den : 64'd0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            v0 = 64'(waypoint_vals[i0][c]);
            v1 = 64'(waypoint_vals[lo][c]);
            p = (v1 - v0) * $signed(f);
            w.vals[c] = 32'(v0 + (p >>> FRAC_BITS));
        end
        return w;
    endfunction

    // Drive one word, wait for accept, update the shadow table.
    // start stays high after the accept; drain drops it, as does a next call that waits a gap.
    task automatic send_word(input op_t op, input logic [31:0] t, input vec_t v);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        sample_time <= t;
        pos_radial <= v[0];
        pos_transverse <= v[1];
        pos_normal <= v[2];
        vel_radial <= v[3];
        vel_transverse <= v[4];
        vel_normal <= v[5];
        do @(posedge clk); while (busy);
        if (op == OP_QUERY)
            pending_states = {pending_states, interpolate_state(t)};
        else if (waypoint_count < DEPTH &&
                 (waypoint_count == 0 || t >= waypoint_time[waypoint_count - 1]))
        begin
            waypoint_time[waypoint_count] = t;
            waypoint_vals[waypoint_count] = v;
            waypoint_count++;
        end
    endtask

    // Compare each strobed word with the oldest prediction.
    always @(posedge clk)
    begin
        state_word_t want;
        vec_t got;
        if (rst_n && valid)
        begin
            got = {out_vel_normal, out_vel_transverse, out_vel_radial,
                   out_pos_normal, out_pos_transverse, out_pos_radial};
            if (pending_states.size() == 0)
                report("result word with nothing pending");
            else
            begin
                want = pending_states.pop_front();
                if (table_empty !== want.empty)
                    report($sformatf("table_empty %b want %b", table_empty, want.empty));
                for (int c = 0; c < NUM_COMP; c++)
                    if (got[c] !== want.vals[c])
                        report($sformatf("component %0d got %h want %h",
                                         c, got[c], want.vals[c]));
            end
        end
    end

    function automatic vec_t random_vec();
        vec_t v;
        for (int c = 0; c < NUM_COMP; c++)
            case ($urandom_range(0, 5))
                0: v[c] = 32'h8000_0000;
                1: v[c] = 32'h7fff_ffff;
                default: v[c] = $urandom;
            endcase
        return v;
    endfunction

    // Drop start and hold until every pending word has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_states.size() != 0);
    endtask

    // Empty table, single waypoint, extremes, equal times, out-of-order.
    task automatic test_directed();
        vec_t lo_v, hi_v;
        lo_v = {NUM_COMP{32'sh8000_0000}};
        hi_v = {NUM_COMP{32'sh7fff_ffff}};
        send_word(OP_QUERY, 32'd0, hi_v);
        send_word(OP_QUERY, 32'hffff_ffff, '0);
        send_word(OP_APPEND, 32'd100, lo_v);
        send_word(OP_QUERY, 32'd0, '0);
        send_word(OP_QUERY, 32'd100, '0);
        send_word(OP_QUERY, 32'hffff_ffff, '0);
        send_word(OP_APPEND, 32'd50, hi_v);        // out of order: drop
        send_word(OP_APPEND, 32'd100, hi_v);       // equal time: keep
        send_word(OP_APPEND, 32'hffff_fff0, lo_v);
        send_word(OP_APPEND, 32'hffff_ffff, hi_v);
        send_word(OP_QUERY, 32'd99, '0);
        send_word(OP_QUERY, 32'd100, '0);
        send_word(OP_QUERY, 32'd101, '0);
        send_word(OP_QUERY, 32'h8000_0000, '0);
        send_word(OP_QUERY, 32'hffff_fff7, '0);
        send_word(OP_QUERY, 32'hffff_fffe, '0);
        send_word(OP_QUERY, 32'hffff_ffff, '0);
        drain();
    endtask

    // Fill to capacity, then check overflow appends are ignored.
    task automatic test_full_table();
        logic [31:0] t;
        t = waypoint_count ? waypoint_time[waypoint_count - 1] : 0;
        while (waypoint_count < DEPTH)
        begin
            send_word(OP_APPEND, t, random_vec());
            if ($urandom_range(0, 3) == 0)
                send_word(OP_QUERY, $urandom, '0);
        end
        send_word(OP_APPEND, 32'hffff_ffff, random_vec());
        send_word(OP_QUERY, 32'hffff_ffff, '0);
        send_word(OP_QUERY, 32'd0, '0);
        // Hold until every pending word has come back.
        drain();
    endtask

    // Random mix on a fresh-looking growth pattern; the table only grows.
    task automatic test_random(input int words);
        logic [31:0] t, last;
        int stride;
        stride = $urandom_range(1, 1 << 20);
        last = 0;
        for (int i = 0; i < words; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                t = last + $urandom_range(0, stride);
                if ($urandom_range(0, 9) == 0) t = $urandom;
                send_word(OP_APPEND, t, random_vec());
                if (waypoint_count) last = waypoint_time[waypoint_count - 1];
            end
            else
            begin
                t = last + $urandom_range(0, stride) - stride / 2;
                if ($urandom_range(0, 7) == 0) t = $urandom;
                send_word(OP_QUERY, t, random_vec());
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        cycle_count = 0;
        waypoint_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_full_table();
        test_random(700);
        drain();
        repeat (QUIET_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_states.size() == 0)
            $display("waypoint_linear_interpolator_test OK");
        else
            $display("waypoint_linear_interpolator_test NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
